// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define SIC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sic assertion failed");

// Checked on every edge, reset included
`define SIC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sic assertion failed");

`endif

// ===== rtl/core/sic_pkg.sv =====
`default_nettype none

package sic_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int TOL_WIDTH   = 16;
    localparam int NUM_FIELDS  = 8;
    localparam int S_TDATA_W   = ((NUM_FIELDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int CLASS_W     = 2;
    localparam int M_TDATA_W   = ((CLASS_W + 7) / 8) * 8;

    // coordinate difference, product of two differences, difference of products
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    // widened box bounds
    localparam int BOX_W   = ((COORD_WIDTH > TOL_WIDTH) ? COORD_WIDTH : TOL_WIDTH) + 2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_point;

    typedef enum logic [CLASS_W-1:0] {
        MEET_NONE   = 2'd0,
        MEET_TOUCH  = 2'd1,
        MEET_PROPER = 2'd2
    } t_meet;

endpackage

`default_nettype wire

// ===== rtl/core/sic_orient.sv =====
`default_nettype none

// Orientation of c against the line a->b: (b-a) x (c-a), products registered
module sic_orient (
    input  wire                                    i_clk,
    input  wire                                    i_en,
    input  sic_pkg::t_point                        i_a,
    input  sic_pkg::t_point                        i_b,
    input  sic_pkg::t_point                        i_c,
    output logic signed [sic_pkg::CROSS_W-1:0]     o_cross
);
    import sic_pkg::*;

    logic signed [DIFF_W-1:0] w_bx;
    logic signed [DIFF_W-1:0] w_by;
    logic signed [DIFF_W-1:0] w_cx;
    logic signed [DIFF_W-1:0] w_cy;
    logic signed [PROD_W-1:0] r_prod_l;
    logic signed [PROD_W-1:0] r_prod_r;

    assign w_bx = DIFF_W'(i_b.x) - DIFF_W'(i_a.x);
    assign w_by = DIFF_W'(i_b.y) - DIFF_W'(i_a.y);
    assign w_cx = DIFF_W'(i_c.x) - DIFF_W'(i_a.x);
    assign w_cy = DIFF_W'(i_c.y) - DIFF_W'(i_a.y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_l <= PROD_W'(w_bx) * PROD_W'(w_cy);
            r_prod_r <= PROD_W'(w_by) * PROD_W'(w_cx);
        end
    end

    assign o_cross = CROSS_W'(r_prod_l) - CROSS_W'(r_prod_r);

endmodule

`default_nettype wire

// ===== rtl/core/segment_intersection_classify.sv =====
// Channel  Dir  Signals                       Content (low bit first)
// s_axis   in   tvalid/tready/tdata[127:0]    As.x As.y Ae.x Ae.y Bs.x Bs.y Be.x Be.y
// m_axis   out  tvalid/tready/tdata[7:0]      meet_class[1:0], zero pad
// cfg      in   we/wdata[15:0]                tolerance
//
// One item per cycle sustained while the sink keeps up; the result register offers the result.
// Stages: input register, cross products in four multiplier pairs,
// compare and classify into the result register.
// Stages advance independently, so bubbles close up under an output stall.
// Reset (synchronous, active low) empties the pipe and clears tolerance.
`default_nettype none

module segment_intersection_classify (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // As.x, As.y, Ae.x, Ae.y, Bs.x, Bs.y, Be.x, Be.y
    input  wire  [sic_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // meet_class, zero pad
    output logic [sic_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    input  wire                                i_cfg_we,
    input  wire  [sic_pkg::TOL_WIDTH-1:0]      i_cfg_wdata
);
    import sic_pkg::*;

    function automatic logic box_hit(input t_point p, input t_point a, input t_point b,
                                     input logic [TOL_WIDTH-1:0] tol);
        logic signed [BOX_W-1:0] ax;
        logic signed [BOX_W-1:0] ay;
        logic signed [BOX_W-1:0] bx;
        logic signed [BOX_W-1:0] by;
        logic signed [BOX_W-1:0] px;
        logic signed [BOX_W-1:0] py;
        logic signed [BOX_W-1:0] t;
        logic signed [BOX_W-1:0] xlo;
        logic signed [BOX_W-1:0] xhi;
        logic signed [BOX_W-1:0] ylo;
        logic signed [BOX_W-1:0] yhi;
        ax  = BOX_W'(a.x);
        ay  = BOX_W'(a.y);
        bx  = BOX_W'(b.x);
        by  = BOX_W'(b.y);
        px  = BOX_W'(p.x);
        py  = BOX_W'(p.y);
        t   = $signed(BOX_W'(tol));
        xlo = ((ax < bx) ? ax : bx) - t;
        xhi = ((ax < bx) ? bx : ax) + t;
        ylo = ((ay < by) ? ay : by) - t;
        yhi = ((ay < by) ? by : ay) + t;
        return (px >= xlo) && (px <= xhi) && (py >= ylo) && (py <= yhi);
    endfunction

    logic [TOL_WIDTH-1:0]           r_tol;
    logic                           r_v1;
    logic                           r_v2;
    logic                           r_v3;
    t_point                         r_pt [4];
    logic [3:0]                     r_box;
    t_meet                          r_class;
    t_meet                          n_class;
    logic                           w_en1;
    logic                           w_en2;
    logic                           w_en3;
    logic [3:0]                     w_box;
    logic signed [CROSS_W-1:0]      w_cross [4];
    logic signed [CROSS_W-1:0]      w_pt;
    logic signed [CROSS_W-1:0]      w_nt;
    logic [3:0]                     w_gt;
    logic [3:0]                     w_lt;
    logic [3:0]                     w_near;
    logic                           w_s1;
    logic                           w_s2;

    assign w_en3           = !r_v3 || i_m_axis_tready;
    assign w_en2           = !r_v2 || w_en3;
    assign w_en1           = !r_v1 || w_en2;
    assign o_s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (w_en1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (w_en1 && i_s_axis_tvalid) begin
            for (int k = 0; k < 4; k++) begin
                r_pt[k].x <= i_s_axis_tdata[(2*k)*COORD_WIDTH +: COORD_WIDTH];
                r_pt[k].y <= i_s_axis_tdata[(2*k+1)*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    // stage 2: products and box tests; points 0..3 are As, Ae, Bs, Be
    sic_orient u_c0 (.i_clk(i_clk), .i_en(w_en2), .i_a(r_pt[0]), .i_b(r_pt[1]),
                     .i_c(r_pt[2]), .o_cross(w_cross[0]));
    sic_orient u_c1 (.i_clk(i_clk), .i_en(w_en2), .i_a(r_pt[0]), .i_b(r_pt[1]),
                     .i_c(r_pt[3]), .o_cross(w_cross[1]));
    sic_orient u_c2 (.i_clk(i_clk), .i_en(w_en2), .i_a(r_pt[2]), .i_b(r_pt[3]),
                     .i_c(r_pt[0]), .o_cross(w_cross[2]));
    sic_orient u_c3 (.i_clk(i_clk), .i_en(w_en2), .i_a(r_pt[2]), .i_b(r_pt[3]),
                     .i_c(r_pt[1]), .o_cross(w_cross[3]));

    assign w_box[0] = box_hit(r_pt[2], r_pt[0], r_pt[1], r_tol);
    assign w_box[1] = box_hit(r_pt[3], r_pt[0], r_pt[1], r_tol);
    assign w_box[2] = box_hit(r_pt[0], r_pt[2], r_pt[3], r_tol);
    assign w_box[3] = box_hit(r_pt[1], r_pt[2], r_pt[3], r_tol);

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_box <= w_box;
        end
    end

    // stage 3: tolerance compares and classification
    assign w_pt = $signed(CROSS_W'(r_tol));
    assign w_nt = -w_pt;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_gt[k]   = w_cross[k] > w_pt;
            w_lt[k]   = w_cross[k] < w_nt;
            w_near[k] = !w_gt[k] && !w_lt[k];
        end
    end

    assign w_s1 = (w_gt[0] && w_lt[1]) || (w_lt[0] && w_gt[1]);
    assign w_s2 = (w_gt[2] && w_lt[3]) || (w_lt[2] && w_gt[3]);

    always_comb begin
        if (w_s1 && w_s2) begin
            n_class = MEET_PROPER;
        end else if ((w_near & r_box) != 4'b0000) begin
            n_class = MEET_TOUCH;
        end else begin
            n_class = MEET_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_class <= n_class;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = M_TDATA_W'(r_class);

endmodule

`default_nettype wire

// ===== rtl/core/sic_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module sic_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_s_axis_tvalid,
    input wire                                o_s_axis_tready,
    input wire                                o_m_axis_tvalid,
    input wire                                i_m_axis_tready,
    input wire  [sic_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);
    logic w_in_acc;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // pipe drained by reset
    `SIC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

    // a free output stage always lets an item in
    `SIC_ASSERT(a_ready_free, i_clk, i_rst_n,
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)

    // result offered once the item has passed the input, product and result registers, when the sink keeps up
    `SIC_ASSERT(a_latency, i_clk, i_rst_n,
        w_in_acc ##1 i_m_axis_tready ##1 i_m_axis_tready |=> o_m_axis_tvalid)

    // stalled result holds
    `SIC_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))

endmodule

bind segment_intersection_classify sic_checker u_sic_checker (.*);

`default_nettype wire
